[rtl/icsb_pkg.sv]
// Package: shared types and constants for the indexed-color sprite blitter.
`default_nettype none
package icsb_pkg;

  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int DEF_ADDR_BITS       = 24;

  localparam int ADDR_OUT_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_PIXEL   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] color_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic                  write_enable;
    logic [ADDR_OUT_W-1:0] write_address;
    logic [31:0]           write_data;
    logic                  wide_write;
    logic                  out_of_range;
    logic                  frame_done;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    rgb_t       rgb;
  } pal_wr_t;

endpackage
`default_nettype wire

[rtl/icsb_palette.sv]
// Palette RAM: one write port, one registered read port.
`default_nettype none
module icsb_palette #(
  parameter int PALETTE_ENTRIES = icsb_pkg::DEF_PALETTE_ENTRIES
) (
  input  wire logic            clk,
  input  wire icsb_pkg::pal_wr_t wr,
  input  wire logic            rd_en,
  input  wire logic [7:0]      rd_idx,
  output icsb_pkg::rgb_t       rd_rgb
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  icsb_pkg::rgb_t mem [PALETTE_ENTRIES];
  logic           wr_ok;

  assign wr_ok = wr.en && ({1'b0, wr.idx} < 9'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.idx[IDX_W-1:0]] <= wr.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rgb <= mem[rd_idx[IDX_W-1:0]];
    end
  end

endmodule
`default_nettype wire

[rtl/indexed_color_sprite_blitter.sv]
// Top level: palette lookup, pixel packing and framebuffer address generation.
// One item per clock is accepted while in_stall is low. A pixel transaction reaches the output
// register through the pipeline stages: the palette RAM read is registered at the accepting
// edge into stage 1, stage 2 registers the row-times-pitch multiply and packing, and the
// output register takes the final address add and range check. Palette loads and position
// restarts take effect at acceptance and give no result. The palette is not cleared after
// reset; slots must be loaded before use.
// in_stall rises only when every pipeline stage holds a transaction and out_stall
// is high.
`default_nettype none
module indexed_color_sprite_blitter #(
  parameter int PALETTE_ENTRIES = icsb_pkg::DEF_PALETTE_ENTRIES,
  parameter int ADDR_BITS       = icsb_pkg::DEF_ADDR_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire icsb_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output icsb_pkg::out_item_t                     out_item,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [icsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [icsb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SUM_W = 35;

  // configuration
  logic [15:0] left_r, top_r, width_r, height_r, pitch_r;
  logic [8:0]  transp_r;
  logic        mode_r;
  logic [23:0] base_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= 16'd1;
      height_r <= 16'd1;
      transp_r <= 9'd256;
      pitch_r  <= '0;
      mode_r   <= 1'b1;
      base_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        icsb_pkg::CFG_LEFT:   left_r   <= cfg_data[15:0];
        icsb_pkg::CFG_TOP:    top_r    <= cfg_data[15:0];
        icsb_pkg::CFG_WIDTH:  width_r  <= cfg_data[15:0];
        icsb_pkg::CFG_HEIGHT: height_r <= cfg_data[15:0];
        icsb_pkg::CFG_TRANSP: transp_r <= cfg_data[8:0];
        icsb_pkg::CFG_PITCH:  pitch_r  <= cfg_data[15:0];
        icsb_pkg::CFG_MODE:   mode_r   <= cfg_data[0];
        icsb_pkg::CFG_BASE:   base_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  logic s1_v_r, s2_v_r, out_valid_r;
  logic out_en, s2_en, s1_en;
  logic in_acc, pix_acc;

  assign out_en   = !out_valid_r || !out_stall;
  assign s2_en    = !s2_v_r || out_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_stall = !s1_en;
  assign in_acc   = in_valid && !in_stall;
  assign pix_acc  = in_acc && (in_item.opcode == icsb_pkg::OP_PIXEL);

  // palette
  icsb_pkg::pal_wr_t pal_wr;
  icsb_pkg::rgb_t    pal_rgb;

  always_comb begin
    pal_wr.en        = in_acc && (in_item.opcode == icsb_pkg::OP_LOAD);
    pal_wr.idx       = in_item.color_index;
    pal_wr.rgb.red   = in_item.red_in;
    pal_wr.rgb.green = in_item.green_in;
    pal_wr.rgb.blue  = in_item.blue_in;
  end

  icsb_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .wr     (pal_wr),
    .rd_en  (pix_acc),
    .rd_idx (in_item.color_index),
    .rd_rgb (pal_rgb)
  );

  // position
  logic [15:0] col_r, row_r, col_nxt, row_nxt;
  logic [16:0] col_inc, row_inc;
  logic        last_col, last_row;

  assign col_inc  = {1'b0, col_r} + 17'd1;
  assign row_inc  = {1'b0, row_r} + 17'd1;
  assign last_col = col_inc >= {1'b0, width_r};
  assign last_row = row_inc >= {1'b0, height_r};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc && (in_item.opcode == icsb_pkg::OP_RESTART)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (pix_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? 16'd0 : row_inc[15:0];
      end else begin
        col_nxt = col_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: palette read in flight
  logic [16:0] s1_xs_r, s1_ys_r;
  logic        s1_opaque_r, s1_done_r, s1_inpal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_xs_r     <= {1'b0, left_r} + {1'b0, col_r};
      s1_ys_r     <= {1'b0, top_r} + {1'b0, row_r};
      s1_opaque_r <= {1'b0, in_item.color_index} != transp_r;
      s1_done_r   <= last_col && last_row;
      s1_inpal_r  <= {1'b0, in_item.color_index} < 9'(PALETTE_ENTRIES);
    end
  end

  // stage 2: multiply and pack
  icsb_pkg::rgb_t rgb;
  logic [32:0]    s2_prod_r;
  logic [24:0]    s2_part_r;
  logic [31:0]    s2_data_r;
  logic           s2_opaque_r, s2_done_r;
  logic [18:0]    xs_bytes;

  assign rgb      = s1_inpal_r ? pal_rgb : '0;
  assign xs_bytes = mode_r ? {s1_xs_r, 2'b00} : {1'b0, s1_xs_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_v_r) begin
      s2_prod_r   <= s1_ys_r * pitch_r;
      s2_part_r   <= {1'b0, base_r} + {6'b0, xs_bytes};
      s2_data_r   <= mode_r ? {8'h00, rgb.red, rgb.green, rgb.blue}
                            : {16'h0000, rgb.red[7:3], rgb.green[7:2], rgb.blue[7:3]};
      s2_opaque_r <= s1_opaque_r;
      s2_done_r   <= s1_done_r;
    end
  end

  // output stage: address sum and range check
  logic [SUM_W-1:0] addr;
  logic             oor;

  assign addr = {2'b00, s2_prod_r} + {10'b0, s2_part_r};
  assign oor  = |addr[SUM_W-1:ADDR_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_v_r) begin
      out_item.write_enable  <= s2_opaque_r && !oor;
      out_item.write_address <= oor ? '0 : addr[icsb_pkg::ADDR_OUT_W-1:0];
      out_item.write_data    <= s2_data_r;
      out_item.wide_write    <= mode_r;
      out_item.out_of_range  <= oor;
      out_item.frame_done    <= s2_done_r;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_pix_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pix_acc |=> s1_v_r)
    else $error("accepted pixel did not enter stage 1");

  a_oor_suppress: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_of_range |-> !out_item.write_enable &&
      (out_item.write_address == '0))
    else $error("out-of-range write not suppressed");

  a_held_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && s2_v_r && out_valid_r)
    else $error("input stalled with a free stage");

endmodule
`default_nettype wire
